>>> sv/sdoc_pkg.sv
// Package with the types and constants of the expedited SDO client.
`default_nettype none
package sdoc_pkg;

   // Kind of request that arrives on the request channel.
   typedef enum logic [1:0] {
      KIND_WRITE = 2'd0,
      KIND_READ  = 2'd1,
      KIND_FRAME = 2'd2,
      KIND_TICK  = 2'd3
   } kind_type;

   // Completion status codes.
   typedef enum logic [2:0] {
      STATUS_CONFIRMED  = 3'd0,
      STATUS_READ       = 3'd1,
      STATUS_ABORT      = 3'd2,
      STATUS_UNEXPECTED = 3'd3,
      STATUS_TIMEOUT    = 3'd4,
      STATUS_REFUSED    = 3'd5
   } status_type;

   localparam logic [10:0] TX_BASE = 11'h600;
   localparam logic [10:0] RX_BASE = 11'h580;

   localparam logic [7:0] CMD_WRITE1 = 8'h2F;
   localparam logic [7:0] CMD_WRITE2 = 8'h2B;
   localparam logic [7:0] CMD_WRITE4 = 8'h23;
   localparam logic [7:0] CMD_READ   = 8'h40;

   localparam logic [7:0] RSP_CONFIRM = 8'h60;
   localparam logic [7:0] RSP_ABORT   = 8'h80;
   localparam logic [7:0] RSP_READ1   = 8'h4F;
   localparam logic [7:0] RSP_READ2   = 8'h4B;
   localparam logic [7:0] RSP_READ4   = 8'h43;

   localparam logic [9:0] TIMEOUT_RESET = 10'd200;

   typedef struct packed {
      logic [1:0]  req_type;
      logic [6:0]  target_node;
      logic [15:0] obj_index;
      logic [7:0]  obj_subindex;
      logic [2:0]  write_size;
      logic [31:0] write_value;
      logic [10:0] rx_id;
      logic [63:0] rx_data;
   } req_payload_type;

   typedef struct packed {
      logic        tx_valid;
      logic [10:0] tx_id;
      logic [63:0] tx_data;
      logic        done_res;
      logic [2:0]  status;
      logic [31:0] read_value;
      logic        fwd_valid;
      logic [10:0] fwd_id;
      logic [63:0] fwd_data;
   } rsp_payload_type;

   // A request held in the input register.
   typedef struct packed {
      logic            valid;
      req_payload_type payload;
   } stage_type;

endpackage
`default_nettype wire

>>> sv/sdoc_if.sv
// Request and response channel interfaces of the expedited SDO client.
`default_nettype none
interface sdoc_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  req_type;
   logic [6:0]  target_node;
   logic [15:0] obj_index;
   logic [7:0]  obj_subindex;
   logic [2:0]  write_size;
   logic [31:0] write_value;
   logic [10:0] rx_id;
   logic [63:0] rx_data;

   modport source (output valid, req_type, target_node, obj_index, obj_subindex,
                   write_size, write_value, rx_id, rx_data, input ready);
   modport sink (input valid, req_type, target_node, obj_index, obj_subindex,
                 write_size, write_value, rx_id, rx_data, output ready);
endinterface

interface sdoc_rsp_if;
   logic        valid;
   logic        ready;
   logic        tx_valid;
   logic [10:0] tx_id;
   logic [63:0] tx_data;
   logic        done_res;
   logic [2:0]  status;
   logic [31:0] read_value;
   logic        fwd_valid;
   logic [10:0] fwd_id;
   logic [63:0] fwd_data;

   modport source (output valid, tx_valid, tx_id, tx_data, done_res, status,
                   read_value, fwd_valid, fwd_id, fwd_data, input ready);
   modport sink (input valid, tx_valid, tx_id, tx_data, done_res, status,
                 read_value, fwd_valid, fwd_id, fwd_data, output ready);
endinterface
`default_nettype wire

>>> sv/sdoc_input_stage.sv
// Input register that captures one request from the request channel.
`default_nettype none
module sdoc_input_stage
   import sdoc_pkg::*;
(
   input  wire logic  clock,
   input  wire logic  reset,
   sdoc_req_if.sink   req,
   output stage_type  stage,
   input  wire logic  take
);

   logic            valid_ff;
   logic            valid_in;
   req_payload_type payload_ff;
   logic            load;

   // The register may load when empty or when its content leaves this cycle.
   assign req.ready = !valid_ff || take;
   assign load      = req.valid && req.ready;

   always_comb begin
      valid_in = valid_ff;
      if (load) begin
         valid_in = 1'b1;
      end else if (take) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         payload_ff <= '{req_type:     req.req_type,
                         target_node:  req.target_node,
                         obj_index:    req.obj_index,
                         obj_subindex: req.obj_subindex,
                         write_size:   req.write_size,
                         write_value:  req.write_value,
                         rx_id:        req.rx_id,
                         rx_data:      req.rx_data};
      end
   end

   assign stage.valid   = valid_ff;
   assign stage.payload = payload_ff;

endmodule
`default_nettype wire

>>> sv/sdoc_engine.sv
// Transfer state, response decode and result register of the SDO client.
`default_nettype none
module sdoc_engine
   import sdoc_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       csr_we,
   input  wire logic [9:0] csr_wdata,
   input  wire stage_type  stage,
   output logic            take,
   sdoc_rsp_if.source      rsp
);

   logic            pending_ff, pending_in;
   logic [6:0]      peer_ff, peer_in;
   logic [9:0]      waited_ff, waited_in;
   logic [9:0]      timeout_ff;
   rsp_payload_type rsp_ff, res;
   logic            rsp_valid_ff;

   kind_type        kind;
   logic [7:0]      cmd;
   logic [31:0]     wpay;
   logic            size_ok;
   logic [10:0]     tick_next;
   logic [7:0]      rx_cmd;
   logic [31:0]     rx_hi;

   assign take = stage.valid && (!rsp_valid_ff || rsp.ready);

   assign kind      = kind_type'(stage.payload.req_type);
   assign tick_next = {1'b0, waited_ff} + 11'd1;
   assign rx_cmd    = stage.payload.rx_data[7:0];
   assign rx_hi     = stage.payload.rx_data[63:32];

   // Command byte and zero padded value for a write or read request.
   always_comb begin
      cmd     = CMD_READ;
      wpay    = '0;
      size_ok = 1'b1;
      if (kind == KIND_WRITE) begin
         unique case (stage.payload.write_size)
            3'd1: begin
               cmd  = CMD_WRITE1;
               wpay = {24'd0, stage.payload.write_value[7:0]};
            end
            3'd2: begin
               cmd  = CMD_WRITE2;
               wpay = {16'd0, stage.payload.write_value[15:0]};
            end
            3'd4: begin
               cmd  = CMD_WRITE4;
               wpay = stage.payload.write_value;
            end
            default: begin
               size_ok = 1'b0;
            end
         endcase
      end
   end

   always_comb begin
      res        = '0;
      pending_in = pending_ff;
      peer_in    = peer_ff;
      waited_in  = waited_ff;
      unique case (kind)
         KIND_WRITE, KIND_READ: begin
            if (pending_ff || !size_ok) begin
               res.done_res = 1'b1;
               res.status   = STATUS_REFUSED;
            end else begin
               res.tx_valid = 1'b1;
               res.tx_id    = TX_BASE + {4'd0, stage.payload.target_node};
               res.tx_data  = {wpay, stage.payload.obj_subindex, stage.payload.obj_index, cmd};
               pending_in   = 1'b1;
               peer_in      = stage.payload.target_node;
               waited_in    = '0;
            end
         end
         KIND_FRAME: begin
            if (pending_ff && stage.payload.rx_id == RX_BASE + {4'd0, peer_ff}) begin
               res.done_res = 1'b1;
               unique case (rx_cmd)
                  RSP_CONFIRM: res.status = STATUS_CONFIRMED;
                  RSP_ABORT:   res.status = STATUS_ABORT;
                  RSP_READ1: begin
                     res.status     = STATUS_READ;
                     res.read_value = {24'd0, rx_hi[7:0]};
                  end
                  RSP_READ2: begin
                     res.status     = STATUS_READ;
                     res.read_value = {16'd0, rx_hi[15:0]};
                  end
                  RSP_READ4: begin
                     res.status     = STATUS_READ;
                     res.read_value = rx_hi;
                  end
                  default:     res.status = STATUS_UNEXPECTED;
               endcase
               pending_in = 1'b0;
               waited_in  = '0;
            end else begin
               res.fwd_valid = 1'b1;
               res.fwd_id    = stage.payload.rx_id;
               res.fwd_data  = stage.payload.rx_data;
            end
         end
         KIND_TICK: begin
            if (pending_ff) begin
               if (tick_next >= {1'b0, timeout_ff}) begin
                  res.done_res = 1'b1;
                  res.status   = STATUS_TIMEOUT;
                  pending_in   = 1'b0;
                  waited_in    = '0;
               end else begin
                  waited_in = tick_next[9:0];
               end
            end
         end
         default: begin
            res = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pending_ff   <= 1'b0;
         peer_ff      <= '0;
         waited_ff    <= '0;
         timeout_ff   <= TIMEOUT_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_we) begin
            timeout_ff <= csr_wdata;
         end
         if (take) begin
            pending_ff <= pending_in;
            peer_ff    <= peer_in;
            waited_ff  <= waited_in;
         end
         if (take) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         rsp_ff <= res;
      end
   end

   assign rsp.valid      = rsp_valid_ff;
   assign rsp.tx_valid   = rsp_ff.tx_valid;
   assign rsp.tx_id      = rsp_ff.tx_id;
   assign rsp.tx_data    = rsp_ff.tx_data;
   assign rsp.done_res   = rsp_ff.done_res;
   assign rsp.status     = rsp_ff.status;
   assign rsp.read_value = rsp_ff.read_value;
   assign rsp.fwd_valid  = rsp_ff.fwd_valid;
   assign rsp.fwd_id     = rsp_ff.fwd_id;
   assign rsp.fwd_data   = rsp_ff.fwd_data;

endmodule
`default_nettype wire

>>> sv/sdo_expedited_client_core.sv
// Top level of the expedited CANopen SDO client.
//
//   Channel  | Direction | Handshake          | Carries
//   ---------+-----------+--------------------+---------------------------------------
//   req      | in        | valid / ready      | write, read, received frame or tick
//   rsp      | out       | valid / ready      | tx frame, completion status, forward
//   csr      | in        | csr_we, no wait    | timeout_ticks (10 bits)
//
// Every request produces exactly one response. A request passes through the
// input register and then the response register, which drives rsp; one
// request can be taken every cycle while rsp is not stalled. The input and
// response registers form a two-entry pipeline; when rsp is stalled the input
// register still takes one more request before req.ready falls.
// Reset clears the transfer state, sets the timeout to 200 ticks and empties
// both registers; no clearing pass is needed.
`default_nettype none
module sdo_expedited_client_core
   import sdoc_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   sdoc_req_if.sink        req,
   sdoc_rsp_if.source      rsp,
   input  wire logic       csr_we,
   input  wire logic [9:0] csr_wdata
);

   stage_type stage;
   logic      take;

   // Input register: holds the accepted request until the engine consumes it.
   sdoc_input_stage u_input_stage (
      .clock (clock),
      .reset (reset),
      .req   (req),
      .stage (stage),
      .take  (take)
   );

   // Engine: builds the request frame or sorts the server's answer, updates
   // the pending transfer and the tick counter, and registers the response.
   sdoc_engine u_engine (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata),
      .stage     (stage),
      .take      (take),
      .rsp       (rsp)
   );

endmodule
`default_nettype wire

>>> sv/sdoc_checker.sv
// Port-level checker for the SDO client and its bind to the top level.
`default_nettype none
module sdoc_checker
   import sdoc_pkg::*;
(
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        rsp_valid,
   input wire logic        rsp_ready,
   input wire logic        tx_valid,
   input wire logic [10:0] tx_id,
   input wire logic        done_res,
   input wire logic [2:0]  status,
   input wire logic [31:0] read_value,
   input wire logic        fwd_valid
);

   // A stalled response stays offered.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("response dropped while stalled");

   // No response right after reset.
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid after reset");

   // A response is at most one of frame, completion and forward.
   a_one_kind: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $countones({tx_valid, done_res, fwd_valid}) <= 1)
      else $error("response carries more than one kind");

   // A read value only comes with a read status.
   a_read_value: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && read_value != 32'd0 |-> done_res && status == STATUS_READ)
      else $error("read value without read status");

   // A request frame always goes to the server request range.
   a_tx_id: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && tx_valid |-> tx_id[10:7] == TX_BASE[10:7])
      else $error("request frame outside server range");

endmodule

bind sdo_expedited_client_core sdoc_checker u_sdoc_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_valid  (rsp.valid),
   .rsp_ready  (rsp.ready),
   .tx_valid   (rsp.tx_valid),
   .tx_id      (rsp.tx_id),
   .done_res   (rsp.done_res),
   .status     (rsp.status),
   .read_value (rsp.read_value),
   .fwd_valid  (rsp.fwd_valid)
);
`default_nettype wire
